[rtl/clse_pkg.sv]
// ----------------------------------------------------------------------------
// Color line slope estimator: shared definitions
// Frame geometry, field widths, register indexes and divider handshake types.
// ----------------------------------------------------------------------------
package clse_pkg;

	localparam int IMAGE_WIDTH   = 80;
	localparam int IMAGE_HEIGHT  = 60;
	localparam int FRACTION_BITS = 8;

	localparam int CHAN_W   = 8;
	localparam int TOL_W    = 8;
	localparam int STEP_W   = 6;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 6;
	localparam int WEIGHT_W = 10;
	localparam int WS_W     = 16;
	localparam int PS_W     = 23;
	localparam int CENT_W   = 15;
	localparam int DIFF_W   = 22;
	localparam int PAIR_W   = 6;
	localparam int SLOPE_W  = 16;

	localparam int DIVIDEND_W = PS_W + FRACTION_BITS;
	localparam int DIVISOR_W  = WS_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP     = 3'd4;

	localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 8'd32;
	localparam logic [STEP_W-1:0] ROW_STEP_RESET  = 6'd4;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} clse_div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} clse_div_rsp_t;

endpackage

[rtl/clse_if.sv]
// ----------------------------------------------------------------------------
// Color line slope estimator: stream interfaces
// Pixel input channel and slope result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clse_pixel_if import clse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              frame_start;

	modport source (output valid, red, green, blue, frame_start, input ready);
	modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface clse_result_if import clse_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SLOPE_W-1:0] slope_q8;
	logic                      slope_valid;
	logic [PAIR_W-1:0]         pairs_used;

	modport source (output valid, slope_q8, slope_valid, pairs_used, input ready);
	modport sink (input valid, slope_q8, slope_valid, pairs_used, output ready);
endinterface

[rtl/clse_match.sv]
// ----------------------------------------------------------------------------
// Color key match
// Flags a pixel whose channels all lie strictly within tolerance of the
// target color and gives its weight, the summed per channel margin.
// ----------------------------------------------------------------------------
module clse_match import clse_pkg::*; (
	input  logic [CHAN_W-1:0]   red,
	input  logic [CHAN_W-1:0]   green,
	input  logic [CHAN_W-1:0]   blue,
	input  logic [CHAN_W-1:0]   target_red,
	input  logic [CHAN_W-1:0]   target_green,
	input  logic [CHAN_W-1:0]   target_blue,
	input  logic [TOL_W-1:0]    tolerance,
	output logic                match,
	output logic [WEIGHT_W-1:0] weight
);

	logic [CHAN_W-1:0] dist_r, dist_g, dist_b;

	always_comb begin
		dist_r = (red > target_red) ? red - target_red : target_red - red;
		dist_g = (green > target_green) ? green - target_green : target_green - green;
		dist_b = (blue > target_blue) ? blue - target_blue : target_blue - blue;
		match  = (dist_r < tolerance) && (dist_g < tolerance) && (dist_b < tolerance);
		// Margins are only meaningful when matched; each distance is below tolerance then.
		weight = WEIGHT_W'(tolerance - dist_r) + WEIGHT_W'(tolerance - dist_g)
			+ WEIGHT_W'(tolerance - dist_b);
	end

endmodule

[rtl/clse_div.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses for one cycle
// when quotient and remainder are ready, and they hold until the next start.
// ----------------------------------------------------------------------------
module clse_div import clse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  clse_div_req_t req,
	output clse_div_rsp_t rsp
);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? DIVISOR_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

[rtl/color_line_slope_estimator_top.sv]
// ----------------------------------------------------------------------------
// Color line slope estimator
// Color keyed weighted row centroids and their mean slope over one frame.
// ----------------------------------------------------------------------------
// Pixels of an 80 by 60 frame arrive in raster order, one word each; a word
// with frame_start set restarts the frame at pixel (0,0). An ordinary pixel
// is taken without a stop. At the last pixel of a row the block stops taking
// pixels while one shared bit-serial divider works: first for the row-step
// remainder that decides whether the row is sampled, then for the Q8 centroid
// when a sampled row has weight. The last pixel of a frame then adds the slope
// division and one result word, with no division when no pair of
// centroids was found; if the previous result has not been taken, the
// block waits for it.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
module color_line_slope_estimator_top import clse_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	clse_pixel_if.sink           pixel,
	clse_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_ROW_MOD   = 6'b000010,
		ST_ROW_DIV   = 6'b000100,
		ST_FRAME     = 6'b001000,
		ST_FRAME_DIV = 6'b010000,
		ST_OUT       = 6'b100000
	} clse_state_t;

	clse_state_t state_q;

	// Configuration registers.
	logic [CHAN_W-1:0] target_red_q, target_green_q, target_blue_q;
	logic [TOL_W-1:0]  tolerance_q;
	logic [STEP_W-1:0] row_step_q;

	// Frame state.
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;
	logic [WS_W-1:0]          ws_q;
	logic [PS_W-1:0]          ps_q;
	logic [CENT_W-1:0]        prev_q;
	logic                     prev_valid_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [PAIR_W-1:0]        pair_q;
	logic signed [SLOPE_W-1:0] slope_calc_q;

	// Result register.
	logic                      res_valid_q;
	logic signed [SLOPE_W-1:0] res_slope_q;
	logic                      res_sv_q;
	logic [PAIR_W-1:0]         res_pairs_q;

	logic                match;
	logic [WEIGHT_W-1:0] weight;
	clse_div_req_t       div_req;
	clse_div_rsp_t       div_rsp;

	logic                        pix_acc;
	logic [COL_W-1:0]            col_eff;
	logic [ROW_W-1:0]            row_eff;
	logic [WS_W-1:0]             ws_add;
	logic [PS_W-1:0]             ps_add;
	logic [WEIGHT_W+COL_W-1:0]   wpos;
	logic                        row_end_px;
	logic [STEP_W-1:0]           step_eff;
	logic                        sampled;
	logic                        need_div;
	logic                        finish_row;
	logic                        row_last;
	logic [2*PAIR_W-1:0]         slope_div;
	logic                        diff_neg;
	logic [DIFF_W-1:0]           diff_mag;
	logic [CENT_W-1:0]           cur_cent;
	logic signed [CENT_W:0]      cent_delta;
	logic signed [SLOPE_W-1:0]   quo_signed;
	logic                        res_free;

	clse_match u_match (
		.red          (pixel.red),
		.green        (pixel.green),
		.blue         (pixel.blue),
		.target_red   (target_red_q),
		.target_green (target_green_q),
		.target_blue  (target_blue_q),
		.tolerance    (tolerance_q),
		.match        (match),
		.weight       (weight)
	);

	clse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		pix_acc    = pixel.valid && pixel.ready;
		col_eff    = pixel.frame_start ? '0 : col_q;
		row_eff    = pixel.frame_start ? '0 : row_q;
		wpos       = (WEIGHT_W+COL_W)'(weight) * (WEIGHT_W+COL_W)'(col_eff);
		ws_add     = (pixel.frame_start ? '0 : ws_q)
			+ (match ? WS_W'(weight) : '0);
		ps_add     = (pixel.frame_start ? '0 : ps_q)
			+ (match ? PS_W'(wpos) : '0);
		row_end_px = col_eff == COL_W'(IMAGE_WIDTH - 1);
		step_eff   = (row_step_q == '0) ? STEP_W'(1) : row_step_q;
		row_last   = row_q == ROW_W'(IMAGE_HEIGHT - 1);

		// A row is sampled when it is a multiple of the step and a whole step
		// still fits below the frame height.
		sampled  = (div_rsp.remainder == '0)
			&& (({1'b0, row_q} + {1'b0, step_eff}) <= (ROW_W+1)'(IMAGE_HEIGHT));
		need_div = sampled && (ws_q != '0);
		finish_row = ((state_q == ST_ROW_MOD) && div_rsp.done && !need_div)
			|| ((state_q == ST_ROW_DIV) && div_rsp.done);

		slope_div = (2*PAIR_W)'(pair_q) * (2*PAIR_W)'(step_eff);
		diff_neg  = diff_q[DIFF_W-1];
		diff_mag  = diff_neg ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);

		cur_cent   = div_rsp.quotient[CENT_W-1:0];
		cent_delta = $signed({1'b0, prev_q}) - $signed({1'b0, cur_cent});
		quo_signed = diff_neg ? -$signed({1'b0, div_rsp.quotient[SLOPE_W-2:0]})
			: $signed({1'b0, div_rsp.quotient[SLOPE_W-2:0]});

		res_free = !res_valid_q || result.ready;

		div_req.start    = 1'b0;
		div_req.dividend = DIVIDEND_W'(row_eff);
		div_req.divisor  = DIVISOR_W'(step_eff);
		unique case (state_q)
			ST_IDLE: begin
				div_req.start = pix_acc && row_end_px;
			end
			ST_ROW_MOD: begin
				div_req.start    = div_rsp.done && need_div;
				div_req.dividend = {ps_q, FRACTION_BITS'(0)};
				div_req.divisor  = ws_q;
			end
			ST_FRAME: begin
				div_req.start    = pair_q != '0;
				div_req.dividend = DIVIDEND_W'(diff_mag);
				div_req.divisor  = DIVISOR_W'(slope_div);
			end
			ST_ROW_DIV, ST_FRAME_DIV, ST_OUT: begin
				div_req.start = 1'b0;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_red_q   <= '0;
			target_green_q <= '0;
			target_blue_q  <= '0;
			tolerance_q    <= TOLERANCE_RESET;
			row_step_q     <= ROW_STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET_RED:   target_red_q   <= cfg_data[CHAN_W-1:0];
				CFG_TARGET_GREEN: target_green_q <= cfg_data[CHAN_W-1:0];
				CFG_TARGET_BLUE:  target_blue_q  <= cfg_data[CHAN_W-1:0];
				CFG_TOLERANCE:    tolerance_q    <= cfg_data[TOL_W-1:0];
				CFG_ROW_STEP:     row_step_q     <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			ws_q         <= '0;
			ps_q         <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			diff_q       <= '0;
			pair_q       <= '0;
			slope_calc_q <= '0;
			res_valid_q  <= 1'b0;
			res_slope_q  <= '0;
			res_sv_q     <= 1'b0;
			res_pairs_q  <= '0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						ws_q  <= ws_add;
						ps_q  <= ps_add;
						row_q <= row_eff;
						if (pixel.frame_start) begin
							prev_q       <= '0;
							prev_valid_q <= 1'b0;
							diff_q       <= '0;
							pair_q       <= '0;
						end
						if (row_end_px) begin
							col_q   <= '0;
							state_q <= ST_ROW_MOD;
						end else begin
							col_q <= col_eff + 1'b1;
						end
					end
				end
				ST_ROW_MOD: begin
					if (div_rsp.done) begin
						if (sampled && (ws_q == '0)) begin
							prev_valid_q <= 1'b0;
						end
						if (need_div) begin
							state_q <= ST_ROW_DIV;
						end
					end
				end
				ST_ROW_DIV: begin
					if (div_rsp.done) begin
						if (prev_valid_q) begin
							diff_q <= diff_q + DIFF_W'(cent_delta);
							pair_q <= pair_q + 1'b1;
						end
						prev_q       <= cur_cent;
						prev_valid_q <= 1'b1;
					end
				end
				ST_FRAME: begin
					slope_calc_q <= '0;
					state_q      <= (pair_q != '0) ? ST_FRAME_DIV : ST_OUT;
				end
				ST_FRAME_DIV: begin
					if (div_rsp.done) begin
						slope_calc_q <= quo_signed;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (res_free) begin
						res_valid_q  <= 1'b1;
						res_slope_q  <= slope_calc_q;
						res_sv_q     <= pair_q != '0;
						res_pairs_q  <= pair_q;
						row_q        <= '0;
						prev_q       <= '0;
						prev_valid_q <= 1'b0;
						diff_q       <= '0;
						pair_q       <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Row wrap-up, shared by the path without a centroid division and the centroid path.
			if (finish_row) begin
				ws_q <= '0;
				ps_q <= '0;
				if (row_last) begin
					state_q <= ST_FRAME;
				end else begin
					row_q   <= row_q + 1'b1;
					state_q <= ST_IDLE;
				end
			end
		end
	end

	assign pixel.ready        = state_q == ST_IDLE;
	assign result.valid       = res_valid_q;
	assign result.slope_q8    = res_slope_q;
	assign result.slope_valid = res_sv_q;
	assign result.pairs_used  = res_pairs_q;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Color line slope estimator testbench
// Sends frames of RGB pixels that hold colored lines of random position, tilt,
// width and gaps, plus noise and broken frames, under random register
// settings. A local predictor keeps its own row sums and centroids and works
// out the slope word of every frame. Each result word is checked field by field.
// ----------------------------------------------------------------------------
module tb_top import clse_pkg::*; ();

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              frame_start;
	} pixel_word_t;

	typedef struct {
		logic signed [SLOPE_W-1:0] slope_q8;
		logic                      slope_valid;
		logic [PAIR_W-1:0]         pairs_used;
	} slope_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	clse_pixel_if  pixel_ch ();
	clse_result_if result_ch ();

	color_line_slope_estimator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of the registers and the frame state.
	logic [CHAN_W-1:0] key_red;
	logic [CHAN_W-1:0] key_green;
	logic [CHAN_W-1:0] key_blue;
	logic [TOL_W-1:0]  key_tol;
	logic [STEP_W-1:0] key_step;

	int unsigned pix_col;
	int unsigned pix_row;
	longint      row_weight;
	longint      row_moment;
	longint      last_centroid;
	bit          last_centroid_ok;
	longint      shift_sum;
	int unsigned pair_total;

	slope_word_t expected_slopes[$];
	int          error_count = 0;
	bit          pixel_gaps_on = 1'b1;
	bit          result_stalls_on = 1'b1;
	int          stall_left = 0;

	function automatic int chan_dist(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic int sample_stride();
		return (key_step == '0) ? 1 : int'(key_step);
	endfunction

	task automatic clear_frame_sums();
		pix_col = 0;
		pix_row = 0;
		row_weight = 0;
		row_moment = 0;
		last_centroid = 0;
		last_centroid_ok = 1'b0;
		shift_sum = 0;
		pair_total = 0;
	endtask

	task automatic close_row();
		int     stride;
		longint centroid;
		stride = sample_stride();
		if ((pix_row % stride == 0) && (pix_row / stride < IMAGE_HEIGHT / stride)) begin
			if (row_weight != 0) begin
				centroid = (row_moment << FRACTION_BITS) / row_weight;
				if (last_centroid_ok) begin
					shift_sum += last_centroid - centroid;
					pair_total++;
				end
				last_centroid = centroid;
				last_centroid_ok = 1'b1;
			end else begin
				last_centroid_ok = 1'b0;
			end
		end
		row_weight = 0;
		row_moment = 0;
	endtask

	task automatic predict_pixel(input pixel_word_t px);
		int          dr, dg, db;
		longint      w, slope;
		slope_word_t res;
		if (px.frame_start)
			clear_frame_sums();
		dr = chan_dist(px.red, key_red);
		dg = chan_dist(px.green, key_green);
		db = chan_dist(px.blue, key_blue);
		if (dr < int'(key_tol) && dg < int'(key_tol) && db < int'(key_tol)) begin
			w = 3 * int'(key_tol) - dr - dg - db;
			row_weight += w;
			row_moment += w * pix_col;
		end
		if (pix_col + 1 < IMAGE_WIDTH) begin
			pix_col++;
		end else begin
			close_row();
			pix_col = 0;
			if (pix_row + 1 < IMAGE_HEIGHT) begin
				pix_row++;
			end else begin
				// Last pixel of the frame: one slope word, then a fresh frame.
				slope = 0;
				if (pair_total != 0) begin
					slope = shift_sum / (longint'(pair_total) * sample_stride());
					if (slope > 32767)
						slope = 32767;
					if (slope < -32768)
						slope = -32768;
				end
				res.slope_q8 = slope[SLOPE_W-1:0];
				res.slope_valid = (pair_total != 0);
				res.pairs_used = PAIR_W'((pair_total > 63) ? 63 : pair_total);
				expected_slopes.push_back(res);
				clear_frame_sums();
			end
		end
	endtask

	task automatic send_pixel(input pixel_word_t px);
		int gap;
		if (pixel_gaps_on && $urandom_range(7) == 0) begin
			gap = $urandom_range(6, 1);
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid       <= 1'b1;
		pixel_ch.red         <= px.red;
		pixel_ch.green       <= px.green;
		pixel_ch.blue        <= px.blue;
		pixel_ch.frame_start <= px.frame_start;
		@(posedge clk);
		while (!pixel_ch.ready)
			@(posedge clk);
		predict_pixel(px);
	endtask

	// Lowers valid and holds off until the block has delivered every slope word
	// and finished any row end that is still in flight.
	task automatic wait_drained();
		pixel_ch.valid <= 1'b0;
		while (expected_slopes.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] tol, input logic [7:0] step);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TARGET_RED;
		cfg_data  <= r;
		@(posedge clk);
		key_red = r;
		cfg_index <= CFG_TARGET_GREEN;
		cfg_data  <= g;
		@(posedge clk);
		key_green = g;
		cfg_index <= CFG_TARGET_BLUE;
		cfg_data  <= b;
		@(posedge clk);
		key_blue = b;
		cfg_index <= CFG_TOLERANCE;
		cfg_data  <= tol;
		@(posedge clk);
		key_tol = tol;
		cfg_index <= CFG_ROW_STEP;
		cfg_data  <= step;
		@(posedge clk);
		key_step = step[STEP_W-1:0];
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CHAN_W-1:0] near_key(input logic [CHAN_W-1:0] base);
		int span, v;
		span = (key_tol > 0) ? int'(key_tol) - 1 : 0;
		v = int'(base) + int'($urandom_range(2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CHAN_W-1:0];
	endfunction

	function automatic pixel_word_t random_pixel();
		pixel_word_t px;
		px.red = CHAN_W'($urandom_range(255));
		px.green = CHAN_W'($urandom_range(255));
		px.blue = CHAN_W'($urandom_range(255));
		px.frame_start = 1'b0;
		return px;
	endfunction

	function automatic pixel_word_t key_pixel();
		pixel_word_t px;
		px.red = near_key(key_red);
		px.green = near_key(key_green);
		px.blue = near_key(key_blue);
		px.frame_start = 1'b0;
		return px;
	endfunction

	// One whole frame with a line whose center starts at column c0 and moves
	// slope16/16 columns per row. Blank rows give invalid samples.
	task automatic send_frame(input int c0, input int slope16, input int half_w,
			input int blank_pct, input int noise_pct, input bit fs_first);
		pixel_word_t px;
		int          center;
		bit          blank;
		bit          restart;
		restart = fs_first || pix_col != 0 || pix_row != 0;
		for (int r = 0; r < IMAGE_HEIGHT; r++) begin
			center = c0 + (slope16 * r) / 16;
			blank = int'($urandom_range(99)) < blank_pct;
			for (int c = 0; c < IMAGE_WIDTH; c++) begin
				if (int'($urandom_range(99)) < noise_pct) begin
					px = random_pixel();
				end else if (!blank && c >= center - half_w && c <= center + half_w) begin
					px = key_pixel();
				end else begin
					px.red = key_red ^ 8'h80;
					px.green = key_green ^ 8'h80;
					px.blue = key_blue ^ 8'h80;
				end
				px.frame_start = (r == 0 && c == 0) ? restart : 1'b0;
				send_pixel(px);
			end
		end
	endtask

	// A run of pixels that does not reach the end of a frame.
	task automatic send_fragment(input int count, input bit fs_first);
		pixel_word_t px;
		for (int i = 0; i < count; i++) begin
			px = ($urandom_range(1) == 0) ? random_pixel() : key_pixel();
			px.frame_start = (i == 0) ? fs_first : ($urandom_range(511) == 0);
			send_pixel(px);
		end
	endtask

	task automatic randomize_settings();
		logic [7:0] tol, step;
		case ($urandom_range(7))
			0: tol = 8'd0;
			1: tol = 8'd255;
			2: tol = 8'd1;
			3: tol = 8'($urandom_range(255));
			default: tol = 8'($urandom_range(96, 8));
		endcase
		case ($urandom_range(9))
			0: step = 8'd1;
			1: step = 8'd60;
			2: step = 8'd0;
			3: step = 8'($urandom_range(63, 61));
			4: step = 8'($urandom_range(60, 1));
			5: step = 8'($urandom_range(255));
			default: step = 8'($urandom_range(8, 2));
		endcase
		apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), tol, step);
	endtask

	task automatic test_reset_settings();
		// Black line against mid gray, with the register values left from reset.
		send_frame(8, 12, 2, 5, 3, 1'b1);
	endtask

	task automatic test_empty_frame();
		send_frame(0, 0, 0, 100, 0, 1'b0);
	endtask

	task automatic test_channel_extremes();
		apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd4);
		send_frame(20, 6, 2, 0, 30, 1'b1);
		apply_settings(8'd0, 8'd0, 8'd0, 8'd255, 8'd2);
		send_frame(60, -6, 3, 0, 30, 1'b0);
		// With a tolerance of one only the exact color matches.
		apply_settings(8'd255, 8'd0, 8'd255, 8'd1, 8'd3);
		send_frame(30, 4, 1, 15, 0, 1'b0);
	endtask

	task automatic test_zero_tolerance();
		apply_settings(8'd100, 8'd100, 8'd100, 8'd0, 8'd4);
		send_frame(40, 3, 4, 0, 20, 1'b0);
	endtask

	task automatic test_row_step_range();
		logic [7:0] steps[7];
		steps = '{8'd1, 8'd60, 8'd7, 8'd0, 8'd63, 8'd30, 8'hC5};
		for (int i = 0; i < 7; i++) begin
			apply_settings(8'd30, 8'd200, 8'd120, 8'd40, steps[i]);
			send_frame(15 + i * 5, 10 - 3 * i, 2, 10, 2, 1'b0);
		end
	endtask

	task automatic test_frame_restart();
		apply_settings(8'd60, 8'd180, 8'd20, 8'd48, 8'd3);
		send_fragment(37, 1'b1);
		send_frame(10, 8, 2, 10, 0, 1'b1);
		// Runs on from the frame end without a start mark, stopping on a row edge.
		send_fragment(IMAGE_WIDTH * 7, 1'b0);
		send_frame(70, -12, 1, 0, 5, 1'b1);
		// The start mark lands where the last pixel of the frame would be.
		send_fragment(IMAGE_WIDTH * IMAGE_HEIGHT - 1, 1'b1);
		send_frame(40, 0, 3, 0, 0, 1'b1);
		send_frame(5, 16, 2, 0, 0, 1'b0);
	endtask

	task automatic test_result_drain();
		pixel_gaps_on = 1'b0;
		send_frame(50, -8, 2, 0, 0, 1'b0);
		wait_drained();
		send_frame(25, 9, 1, 20, 2, 1'b0);
		pixel_gaps_on = 1'b1;
	endtask

	task automatic test_random_frames();
		for (int n = 0; n < 32; n++) begin
			if (n >= 28) begin
				pixel_gaps_on = 1'b0;
				result_stalls_on = 1'b0;
			end else begin
				pixel_gaps_on = ($urandom_range(3) != 0);
				result_stalls_on = ($urandom_range(3) != 0);
			end
			if (n == 0 || $urandom_range(2) == 0)
				randomize_settings();
			case ($urandom_range(9))
				7: send_frame(0, 0, 0, 0, 100, 1'($urandom_range(1)));
				8: begin
					send_fragment($urandom_range(900, 1), 1'($urandom_range(1)));
					send_frame($urandom_range(79), int'($urandom_range(40)) - 20,
						$urandom_range(4), $urandom_range(30), $urandom_range(5), 1'b1);
				end
				9: send_frame($urandom_range(79), int'($urandom_range(40)) - 20,
					$urandom_range(4), $urandom_range(30), 40, 1'($urandom_range(1)));
				default: send_frame($urandom_range(79), int'($urandom_range(40)) - 20,
					$urandom_range(4), $urandom_range(30), $urandom_range(5),
					1'($urandom_range(1)));
			endcase
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (result_stalls_on && $urandom_range(3) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(6, 1) - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_slopes
		slope_word_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_slopes.size() == 0) begin
				$display("%0t unexpected slope word: expected none, actual %0d/%0b/%0d", $time,
					result_ch.slope_q8, result_ch.slope_valid, result_ch.pairs_used);
				error_count++;
			end else begin
				want = expected_slopes.pop_front();
				if (result_ch.slope_q8 !== want.slope_q8) begin
					$display("%0t slope_q8: expected %0d, actual %0d", $time,
						want.slope_q8, result_ch.slope_q8);
					error_count++;
				end
				if (result_ch.slope_valid !== want.slope_valid) begin
					$display("%0t slope_valid: expected %0b, actual %0b", $time,
						want.slope_valid, result_ch.slope_valid);
					error_count++;
				end
				if (result_ch.pairs_used !== want.pairs_used) begin
					$display("%0t pairs_used: expected %0d, actual %0d", $time,
						want.pairs_used, result_ch.pairs_used);
					error_count++;
				end
			end
		end
	end

	initial begin
		#30000000;
		$display("color_line_slope_estimator_top: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		pixel_ch.valid = 1'b0;
		pixel_ch.red = '0;
		pixel_ch.green = '0;
		pixel_ch.blue = '0;
		pixel_ch.frame_start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET_RED;
		cfg_data = '0;
		key_red = '0;
		key_green = '0;
		key_blue = '0;
		key_tol = TOLERANCE_RESET;
		key_step = ROW_STEP_RESET;
		clear_frame_sums();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_empty_frame();
		test_channel_extremes();
		test_zero_tolerance();
		test_row_step_range();
		test_frame_restart();
		test_result_drain();
		test_random_frames();

		pixel_ch.valid <= 1'b0;
		while (expected_slopes.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("color_line_slope_estimator_top: match");
		else
			$display("color_line_slope_estimator_top: mismatch");
		$finish;
	end

endmodule
